### hdl/itw_pkg.sv
`default_nettype none
package itw_pkg;

   localparam int MAX_CONNS = 64;
   localparam int MAX_SLOTS = 32;

   localparam int ID_W   = 6;
   localparam int SLOT_W = 5;
   localparam int LEN_W  = 6;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);
   localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_SLOTS);

   // register index as seen on paddr[2]
   localparam logic REG_WHEEL_LENGTH = 1'b0;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MARK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   typedef struct packed {
      logic              wr_en;
      logic [ID_W-1:0]   wr_id;
      logic [SLOT_W-1:0] wr_slot;
      logic [SLOT_W-1:0] cur_slot;
      logic              mark;
      logic              shift;
   } cell_ctl_type;

endpackage
`default_nettype wire

### hdl/idle_timeout_wheel.sv
// activity-only item: busy stays low, no results
// tick item: busy through the mark state, the scan state that visits every connection
//   cell, and a final flush state; an id found in the scan is held back and goes out
//   registered on the next hit or in the flush, the final beat in the same cycle busy falls
// the scan covers every cell, as the hit flags shift one cell per cycle down the chain
// reset: every connection invalid, slot index zero, wheel length 32
`default_nettype none
module idle_timeout_wheel (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_activity,
   input  wire logic [itw_pkg::ID_W-1:0]      req_conn_id,
   input  wire logic                          req_tick,
   output logic                               rsp_strobe,
   output logic [itw_pkg::ID_W-1:0]           rsp_expired_conn,
   output logic                               rsp_last,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic [1:0]                   state_ff, state_in;
   logic [itw_pkg::SLOT_W-1:0]   cur_ff, cur_in;
   logic [itw_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [itw_pkg::ID_W-1:0]     scan_ff, scan_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [itw_pkg::ID_W-1:0]     pend_id_ff, pend_id_in;
   logic                         strobe_ff, strobe_in;
   logic [itw_pkg::ID_W-1:0]     out_id_ff, out_id_in;
   logic                         out_last_ff, out_last_in;

   logic                         accept;
   logic                         csr_wr;
   logic [itw_pkg::LEN_W-1:0]    len_use;
   logic [itw_pkg::LEN_W-1:0]    next_slot;
   itw_pkg::cell_ctl_type        ctl;
   logic [itw_pkg::MAX_CONNS-1:0] hit;

   assign busy   = (state_ff != itw_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[2] == itw_pkg::REG_WHEEL_LENGTH);
   assign pready = 1'b1;

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == itw_pkg::REG_WHEEL_LENGTH) begin
         prdata = {{(32 - itw_pkg::LEN_W){1'b0}}, len_ff};
      end
   end

   always_comb begin
      len_use = len_ff;
      if (len_ff < itw_pkg::LEN_MIN) begin
         len_use = itw_pkg::LEN_MIN;
      end else if (len_ff > itw_pkg::LEN_MAX) begin
         len_use = itw_pkg::LEN_MAX;
      end
      next_slot = {1'b0, cur_ff} + itw_pkg::LEN_W'(1);
      if (next_slot >= len_use) begin
         next_slot = '0;
      end
   end

   always_comb begin
      ctl.wr_en    = accept && req_activity;
      ctl.wr_id    = req_conn_id;
      ctl.wr_slot  = cur_ff;
      ctl.cur_slot = cur_ff;
      ctl.mark     = (state_ff == itw_pkg::ST_MARK);
      ctl.shift    = (state_ff == itw_pkg::ST_SCAN);
   end

   for (genvar g = 0; g < itw_pkg::MAX_CONNS; g++) begin : g_cell
      logic nxt_hit;
      if (g == itw_pkg::MAX_CONNS - 1) begin : g_end
         assign nxt_hit = 1'b0;
      end else begin : g_mid
         assign nxt_hit = hit[g+1];
      end
      itw_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_id       (itw_pkg::ID_W'(g)),
         .ctl           (ctl),
         .hit_from_next (nxt_hit),
         .hit_out       (hit[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      len_in        = len_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      strobe_in     = 1'b0;
      out_id_in     = out_id_ff;
      out_last_in   = out_last_ff;
      if (csr_wr) begin
         len_in = pwdata[itw_pkg::LEN_W-1:0];
      end
      case (state_ff)
         itw_pkg::ST_IDLE: begin
            if (accept && req_tick) begin
               cur_in   = next_slot[itw_pkg::SLOT_W-1:0];
               state_in = itw_pkg::ST_MARK;
            end
         end
         itw_pkg::ST_MARK: begin
            scan_in       = '0;
            pend_valid_in = 1'b0;
            state_in      = itw_pkg::ST_SCAN;
         end
         itw_pkg::ST_SCAN: begin
            // hold one hit back so the final beat can carry last
            if (hit[0]) begin
               if (pend_valid_ff) begin
                  strobe_in   = 1'b1;
                  out_id_in   = pend_id_ff;
                  out_last_in = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = scan_ff;
            end
            scan_in = scan_ff + itw_pkg::ID_W'(1);
            if (scan_ff == itw_pkg::ID_W'(itw_pkg::MAX_CONNS - 1)) begin
               state_in = itw_pkg::ST_DONE;
            end
         end
         itw_pkg::ST_DONE: begin
            if (pend_valid_ff) begin
               strobe_in   = 1'b1;
               out_id_in   = pend_id_ff;
               out_last_in = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = itw_pkg::ST_IDLE;
         end
         default: begin
            state_in = itw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itw_pkg::ST_IDLE;
         cur_ff        <= '0;
         len_ff        <= itw_pkg::LEN_RESET;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         len_ff        <= len_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pend_id_ff  <= pend_id_in;
      out_id_ff   <= out_id_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_expired_conn = out_id_ff;
   assign rsp_last         = out_last_ff;

   a_strobe_from_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == itw_pkg::ST_SCAN
                      || $past(state_ff) == itw_pkg::ST_DONE))
      else $error("result beat outside a scan");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("beat after the last of a run");

   a_tick_marks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tick) |=> (state_ff == itw_pkg::ST_MARK))
      else $error("tick did not start a mark cycle");

   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itw_pkg::ST_DONE) |=> (!pend_valid_ff && !busy))
      else $error("pending id left after flush");

endmodule
`default_nettype wire

### hdl/itw_cell.sv
`default_nettype none
module itw_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [itw_pkg::ID_W-1:0]  cell_id,
   input  wire itw_pkg::cell_ctl_type     ctl,
   input  wire logic                      hit_from_next,
   output logic                           hit_out
);

   logic                        valid_ff, valid_in;
   logic [itw_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic                        hit_ff, hit_in;
   logic                        match;
   logic                        wr_here;

   always_comb begin
      wr_here  = ctl.wr_en && (ctl.wr_id == cell_id);
      match    = valid_ff && (slot_ff == ctl.cur_slot);
      valid_in = valid_ff;
      slot_in  = slot_ff;
      hit_in   = hit_ff;
      if (wr_here) begin
         valid_in = 1'b1;
         slot_in  = ctl.wr_slot;
      end else if (ctl.mark && match) begin
         valid_in = 1'b0;
      end
      // hit flags march toward cell 0 during the scan
      if (ctl.mark) begin
         hit_in = match;
      end else if (ctl.shift) begin
         hit_in = hit_from_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      hit_ff  <= hit_in;
   end

   assign hit_out = hit_ff;

endmodule
`default_nettype wire

### dv/tb_top.sv
module tb_top;

   localparam int STALL_LIMIT = 4000;
   localparam int SCAN_CYCLES = itw_pkg::MAX_CONNS + 8;
   localparam logic [2:0] WHEEL_LENGTH_ADDR = {itw_pkg::REG_WHEEL_LENGTH, 2'b00};

   typedef struct packed {
      logic                     act;
      logic [itw_pkg::ID_W-1:0] id;
      logic                     tk;
   } conn_cmd_type;

   typedef struct packed {
      logic [itw_pkg::ID_W-1:0] conn;
      logic                     last;
   } expiry_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_activity = 1'b0;
   logic [itw_pkg::ID_W-1:0]   req_conn_id = '0;
   logic                       req_tick = 1'b0;
   logic                       rsp_strobe;
   logic [itw_pkg::ID_W-1:0]   rsp_expired_conn;
   logic                       rsp_last;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [2:0]                 paddr = '0;
   logic [31:0]                pwdata = '0;
   logic [31:0]                prdata;
   logic                       pready;

   // predictor state: per-connection valid bit and slot, wheel position and length
   logic                       conn_on [itw_pkg::MAX_CONNS] = '{default: 1'b0};
   logic [itw_pkg::SLOT_W-1:0] conn_slot [itw_pkg::MAX_CONNS] = '{default: '0};
   logic [itw_pkg::SLOT_W-1:0] slot_now = '0;
   logic [itw_pkg::LEN_W-1:0]  wheel_len = itw_pkg::LEN_RESET;

   conn_cmd_type cmd_q [$];
   expiry_type   expiry_q [$];

   int gap_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int cmds_taken = 0;
   int ticks_taken = 0;
   int expiries_seen = 0;
   int length_writes = 0;

   idle_timeout_wheel u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_activity     (req_activity),
      .req_conn_id      (req_conn_id),
      .req_tick         (req_tick),
      .rsp_strobe       (rsp_strobe),
      .rsp_expired_conn (rsp_expired_conn),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // activity refiles the connection first, then a tick advances and expires the new slot
   task automatic file_and_expire(input logic act, input logic [itw_pkg::ID_W-1:0] id,
                                  input logic tk);
      int         len;
      int         nxt;
      int         last_hit;
      expiry_type e;
      if (act && int'(id) < itw_pkg::MAX_CONNS) begin
         conn_on[id] = 1'b1;
         conn_slot[id] = slot_now;
      end
      if (tk) begin
         len = int'(wheel_len);
         if (len < int'(itw_pkg::LEN_MIN)) len = int'(itw_pkg::LEN_MIN);
         if (len > int'(itw_pkg::LEN_MAX)) len = int'(itw_pkg::LEN_MAX);
         nxt = int'(slot_now) + 1;
         if (nxt >= len) nxt = 0;
         slot_now = itw_pkg::SLOT_W'(nxt);
         last_hit = -1;
         for (int i = 0; i < itw_pkg::MAX_CONNS; i++)
            if (conn_on[i] && conn_slot[i] == slot_now) last_hit = i;
         for (int i = 0; i < itw_pkg::MAX_CONNS; i++) begin
            if (conn_on[i] && conn_slot[i] == slot_now) begin
               conn_on[i] = 1'b0;
               e.conn = itw_pkg::ID_W'(i);
               e.last = (i == last_hit);
               expiry_q.push_back(e);
            end
         end
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      conn_cmd_type c;
      int           r;
      if (!reset) begin
         if (start && !busy) begin
            file_and_expire(req_activity, req_conn_id, req_tick);
            cmds_taken++;
            if (req_tick) ticks_taken++;
            r = $urandom_range(0, 99);
            if (r < 60) gap_left = 0;
            else if (r < 90) gap_left = $urandom_range(1, 3);
            else gap_left = $urandom_range(4, 80);
         end
         if (!start || !busy) begin
            if (gap_left == 0 && cmd_q.size() != 0) begin
               c = cmd_q.pop_front();
               start <= 1'b1;
               req_activity <= c.act;
               req_conn_id <= c.id;
               req_tick <= c.tk;
            end else begin
               if (gap_left != 0) gap_left--;
               start <= 1'b0;
            end
         end
      end
   end

   // expiry monitor
   always @(posedge clock) begin : watch_rsp
      expiry_type e;
      if (!reset && rsp_strobe) begin
         if (expiry_q.size() == 0) begin
            $error("unexpected beat: expired_conn=%0d last=%0b", rsp_expired_conn, rsp_last);
            mismatches++;
         end else begin
            e = expiry_q.pop_front();
            expiries_seen++;
            if (rsp_expired_conn !== e.conn) begin
               $error("expired_conn: expected %0d, got %0d", e.conn, rsp_expired_conn);
               mismatches++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0b, got %0b", e.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_cmd(input logic act, input logic [itw_pkg::ID_W-1:0] id,
                            input logic tk);
      conn_cmd_type c;
      c.act = act;
      c.id = id;
      c.tk = tk;
      cmd_q.push_back(c);
   endtask

   // wait for all beats, then let a scan with no hits run out
   task automatic settle();
      @(negedge clock);
      while (cmd_q.size() != 0 || start || busy || expiry_q.size() != 0) @(negedge clock);
      repeat (SCAN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_read_check(input logic [itw_pkg::LEN_W-1:0] want);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= WHEEL_LENGTH_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[itw_pkg::LEN_W-1:0] !== want) begin
         $error("wheel_length: expected %0d, got %0d", want, prdata[itw_pkg::LEN_W-1:0]);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_write(input logic [itw_pkg::LEN_W-1:0] value);
      settle();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= WHEEL_LENGTH_ADDR;
      pwdata <= {26'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      wheel_len = value;
      length_writes++;
      csr_read_check(value);
   endtask

   task automatic run_phase(input logic [itw_pkg::LEN_W-1:0] value, input int n,
                            input int tick_pct);
      logic                     act;
      logic                     tk;
      logic [itw_pkg::ID_W-1:0] id;
      csr_write(value);
      while (n > 0) begin
         act = ($urandom_range(0, 99) < 75);
         tk = ($urandom_range(0, 99) < tick_pct);
         // a hot set of ids gets refiled often, the rest spreads over the table
         if ($urandom_range(0, 1)) id = itw_pkg::ID_W'($urandom_range(0, 7));
         else id = itw_pkg::ID_W'($urandom_range(0, itw_pkg::MAX_CONNS - 1));
         queue_cmd(act, id, tk);
         if (act || tk) n--;
      end
   endtask

   initial begin : stimulus
      int ids [itw_pkg::MAX_CONNS];
      int j;
      int tmp;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_read_check(itw_pkg::LEN_RESET);

      // reset length: empty tick, activity only, both in one beat, an ignored beat
      queue_cmd(1'b0, 6'd0, 1'b1);
      queue_cmd(1'b1, 6'd0, 1'b0);
      queue_cmd(1'b1, 6'd63, 1'b0);
      queue_cmd(1'b0, 6'd63, 1'b0);
      queue_cmd(1'b1, 6'd42, 1'b1);

      // zero runs as the minimum length, refile drops the earlier slot
      csr_write(6'd0);
      queue_cmd(1'b1, 6'd5, 1'b0);
      queue_cmd(1'b0, 6'd63, 1'b1);
      queue_cmd(1'b1, 6'd5, 1'b0);
      queue_cmd(1'b1, 6'd0, 1'b0);
      queue_cmd(1'b1, 6'd63, 1'b0);
      queue_cmd(1'b1, 6'd32, 1'b0);
      queue_cmd(1'b1, 6'd31, 1'b1);
      queue_cmd(1'b0, 6'd21, 1'b1);
      queue_cmd(1'b0, 6'd42, 1'b1);
      queue_cmd(1'b1, 6'd0, 1'b1);

      run_phase(6'd1, 20, 50);
      run_phase(6'd3, 20, 40);
      run_phase(6'd63, 30, 60);
      // shortened while the slot index may sit past the new length
      run_phase(6'd4, 20, 40);
      run_phase(6'd33, 25, 50);

      // every connection filed at once, then expired in one tick
      csr_write(6'd2);
      for (int i = 0; i < itw_pkg::MAX_CONNS; i++) ids[i] = i;
      for (int i = itw_pkg::MAX_CONNS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = ids[i];
         ids[i] = ids[j];
         ids[j] = tmp;
      end
      for (int i = 0; i < itw_pkg::MAX_CONNS; i++)
         queue_cmd(1'b1, itw_pkg::ID_W'(ids[i]), 1'b0);
      queue_cmd(1'b0, 6'd0, 1'b1);
      queue_cmd(1'b0, 6'd0, 1'b1);

      run_phase(6'd32, 20, 50);
      run_phase(itw_pkg::LEN_W'($urandom_range(2, 12)), 25, 40);
      run_phase(6'd5, 20, 40);
      settle();

      $display("covered %0d commands with %0d ticks and %0d expiries checked,",
               cmds_taken, ticks_taken, expiries_seen);
      $display("over %0d wheel length writes including 0, 1, 2, 32, 33 and 63",
               length_writes);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
